FILE: rtl/tsb_pkg.sv
`default_nettype none

package tsb_pkg;

  typedef enum logic [2:0] {
    CFG_TEX_WIDTH   = 3'd0,
    CFG_TEX_HEIGHT  = 3'd1,
    CFG_WRAP_MODE   = 3'd2,
    CFG_FILTER_MODE = 3'd3,
    CFG_FILL_COLOR  = 3'd4
  } cfg_index_t;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic WRAP_FILL   = 1'b0;
  localparam logic WRAP_REPEAT = 1'b1;

  localparam logic FILTER_NEAREST  = 1'b0;
  localparam logic FILTER_BILINEAR = 1'b1;

  localparam int TEX_DIM_BITS  = 7;
  localparam int RAW_ADDR_BITS = 15;

endpackage

`default_nettype wire

FILE: rtl/texture_sampler_bilinear.sv
// texture_sampler_bilinear: one RGBA8 texture, nearest or bilinear sampling
//
// input: a transaction is taken at each rising edge with start high and busy
// low. busy is always low, so one transaction is taken every clock cycle.
// mode selects a texel load (texel_index, texel_rgba) or a sample
// (u_coord, v_coord in signed fixed point with FRAC_BITS fraction bits).
// loads give no result. each sample gives one result on red, green, blue,
// alpha, shown for exactly one cycle with result_strobe high, in sample order.
// the texel store is two copies of one memory, each read at two addresses,
// so the four texels of a footprint are fetched in the same cycle; loads
// write both copies at the same pipeline step as the sample reads.
// config: cfg_write, cfg_index, cfg_data; write only while no sample is in
// flight. reset clears the pipeline and the registers to their defaults;
// the texel store holds nothing defined until loaded. there is no stall:
// the receiver must take each result in the cycle it is shown.
`default_nettype none

module texture_sampler_bilinear
  import tsb_pkg::*;
#(
  parameter int TEXELS    = 4096,
  parameter int FRAC_BITS = 12
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               mode,
  input  wire logic [11:0]        texel_index,
  input  wire logic [31:0]        texel_rgba,
  input  wire logic signed [15:0] u_coord,
  input  wire logic signed [15:0] v_coord,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output logic                    result_strobe,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue,
  output logic [7:0]              alpha
);

  localparam int F   = FRAC_BITS;
  localparam int AW  = (TEXELS > 1) ? $clog2(TEXELS) : 1;
  localparam int WW  = 2 * F + 2;
  localparam int PW  = WW + 8;
  localparam int SW  = WW + 10;
  localparam int DW  = TEX_DIM_BITS;
  localparam int RAW = RAW_ADDR_BITS;
  localparam logic [32:0] RECIP = 33'(((64'd1 << 32) + 64'(TEXELS) - 64'd1) / 64'(TEXELS));
  localparam logic [F:0] ONE = (F + 1)'(1) << F;
  localparam logic signed [17:0] ONE_S = 18'sd1 <<< F;

  // configuration
  logic [DW-1:0] tex_width, tex_height;
  logic          wrap_mode, filter_mode;
  logic [31:0]   fill_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width   <= DW'(1);
      tex_height  <= DW'(1);
      wrap_mode   <= WRAP_FILL;
      filter_mode <= FILTER_BILINEAR;
      fill_color  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TEX_WIDTH:   tex_width   <= cfg_data[DW-1:0];
        CFG_TEX_HEIGHT:  tex_height  <= cfg_data[DW-1:0];
        CFG_WRAP_MODE:   wrap_mode   <= cfg_data[0];
        CFG_FILTER_MODE: filter_mode <= cfg_data[0];
        CFG_FILL_COLOR:  fill_color  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [DW-1:0] w_eff, h_eff, wm1, hm1;
  assign w_eff = (tex_width == '0) ? DW'(1) : tex_width;
  assign h_eff = (tex_height == '0) ? DW'(1) : tex_height;
  assign wm1   = w_eff - DW'(1);
  assign hm1   = h_eff - DW'(1);

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // stage 1: captured transaction
  logic               p1_valid, p1_load;
  logic [11:0]        p1_idx;
  logic [31:0]        p1_rgba;
  logic signed [15:0] p1_u, p1_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= accept;
    end
    p1_load <= (mode == MODE_LOAD);
    p1_idx  <= texel_index;
    p1_rgba <= texel_rgba;
    p1_u    <= u_coord;
    p1_v    <= v_coord;
  end

  logic signed [17:0] su, sv;
  logic               oor, fill1, single1;
  logic [F:0]         ua, va;
  logic [DW-1:0]      mx, my, xr, yr, x1, y1;
  logic [F+DW:0]      sx, sy;
  logic [F-1:0]       fu1, fv1;

  always_comb begin
    su  = 18'(p1_u);
    sv  = 18'(p1_v);
    oor = (su < 0) || (su > ONE_S) || (sv < 0) || (sv > ONE_S);
    ua  = oor ? {1'b0, su[F-1:0]} : su[F:0];
    va  = oor ? {1'b0, sv[F-1:0]} : sv[F:0];
    mx  = (filter_mode == FILTER_NEAREST) ? w_eff : wm1;
    my  = (filter_mode == FILTER_NEAREST) ? h_eff : hm1;
    sx  = (F + DW + 1)'(ua * mx);
    sy  = (F + DW + 1)'(va * my);
    xr  = sx[F+DW-1:F];
    yr  = sy[F+DW-1:F];
    x1  = (xr > wm1) ? wm1 : xr;
    y1  = (yr > hm1) ? hm1 : yr;
    single1 = (filter_mode == FILTER_NEAREST) || (x1 == wm1) || (y1 == hm1);
    fu1 = single1 ? '0 : sx[F-1:0];
    fv1 = single1 ? '0 : sy[F-1:0];
    fill1 = oor && (wrap_mode == WRAP_FILL);
  end

  // stage 2: texel position and weights
  logic          p2_valid, p2_load, p2_fill;
  logic [11:0]   p2_idx;
  logic [31:0]   p2_rgba;
  logic [DW-1:0] p2_x, p2_y;
  logic [F-1:0]  p2_fu, p2_fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
    p2_load <= p1_load;
    p2_fill <= fill1;
    p2_idx  <= p1_idx;
    p2_rgba <= p1_rgba;
    p2_x    <= x1;
    p2_y    <= y1;
    p2_fu   <= fu1;
    p2_fv   <= fv1;
  end

  logic [2*DW-1:0] base;
  logic [RAW-1:0]  addr2 [4];
  logic [F:0]      gu, gv, fu_e, fv_e;
  logic [WW-1:0]   wt2 [4];

  always_comb begin
    base     = (2 * DW)'(p2_y * w_eff) + (2 * DW)'(p2_x);
    addr2[0] = RAW'(base);
    addr2[1] = RAW'(base) + RAW'(1);
    addr2[2] = RAW'(base) + RAW'(w_eff);
    addr2[3] = RAW'(base) + RAW'(w_eff) + RAW'(1);
    fu_e     = {1'b0, p2_fu};
    fv_e     = {1'b0, p2_fv};
    gu       = ONE - fu_e;
    gv       = ONE - fv_e;
    wt2[0]   = WW'(gu * gv);
    wt2[1]   = WW'(fu_e * gv);
    wt2[2]   = WW'(gu * fv_e);
    wt2[3]   = WW'(fu_e * fv_e);
  end

  // stage 3: raw addresses, quotient by texel count
  logic           p3_valid, p3_load, p3_fill;
  logic [11:0]    p3_idx;
  logic [31:0]    p3_rgba;
  logic [RAW-1:0] p3_addr [4];
  logic [WW-1:0]  p3_wt   [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else begin
      p3_valid <= p2_valid;
    end
    p3_load <= p2_load;
    p3_fill <= p2_fill;
    p3_idx  <= p2_idx;
    p3_rgba <= p2_rgba;
    for (int i = 0; i < 4; i++) begin
      p3_addr[i] <= addr2[i];
      p3_wt[i]   <= wt2[i];
    end
  end

  logic [RAW+32:0] qprod [4];
  logic [RAW-1:0]  quot3 [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qprod[i] = (RAW + 33)'(p3_addr[i]) * (RAW + 33)'(RECIP);
      quot3[i] = qprod[i][RAW+31:32];
    end
  end

  // stage 4: remainder, memory access
  logic           p4_valid, p4_load, p4_fill;
  logic [11:0]    p4_idx;
  logic [31:0]    p4_rgba;
  logic [RAW-1:0] p4_addr [4];
  logic [RAW-1:0] p4_quot [4];
  logic [WW-1:0]  p4_wt   [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else begin
      p4_valid <= p3_valid;
    end
    p4_load <= p3_load;
    p4_fill <= p3_fill;
    p4_idx  <= p3_idx;
    p4_rgba <= p3_rgba;
    for (int i = 0; i < 4; i++) begin
      p4_addr[i] <= p3_addr[i];
      p4_quot[i] <= quot3[i];
      p4_wt[i]   <= p3_wt[i];
    end
  end

  logic [31:0]   rem_full [4];
  logic [AW-1:0] rd_addr  [4];
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rem_full[i] = 32'(p4_addr[i]) - 32'(p4_quot[i]) * 32'(TEXELS);
      rd_addr[i]  = rem_full[i][AW-1:0];
    end
    wr_en   = p4_valid && p4_load && (32'(p4_idx) < 32'(TEXELS));
    wr_addr = AW'(p4_idx);
  end

  logic [31:0] mem_a [TEXELS];
  logic [31:0] mem_b [TEXELS];
  logic [31:0] tx    [4];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= p4_rgba;
      mem_b[wr_addr] <= p4_rgba;
    end
    tx[0] <= mem_a[rd_addr[0]];
    tx[1] <= mem_a[rd_addr[1]];
    tx[2] <= mem_b[rd_addr[2]];
    tx[3] <= mem_b[rd_addr[3]];
  end

  // stage 5: texels, weight products
  logic          p5_valid, p5_fill;
  logic [WW-1:0] p5_wt [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      p5_valid <= 1'b0;
    end else begin
      p5_valid <= p4_valid && !p4_load;
    end
    p5_fill <= p4_fill;
    for (int i = 0; i < 4; i++) begin
      p5_wt[i] <= p4_wt[i];
    end
  end

  logic [PW-1:0] prod5 [4][4];

  // texels with zero weight lie outside the footprint and are not used
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        prod5[i][k] = (p5_wt[i] == '0) ? '0
                    : PW'(p5_wt[i]) * PW'(tx[i][31-8*k -: 8]);
      end
    end
  end

  // stage 6: sum
  logic          p6_valid, p6_fill;
  logic [PW-1:0] p6_prod [4][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      p6_valid <= 1'b0;
    end else begin
      p6_valid <= p5_valid;
    end
    p6_fill <= p5_fill;
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        p6_prod[i][k] <= prod5[i][k];
      end
    end
  end

  logic [SW-1:0] acc [4];
  logic [7:0]    chan6 [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      acc[k] = SW'(p6_prod[0][k]) + SW'(p6_prod[1][k])
             + SW'(p6_prod[2][k]) + SW'(p6_prod[3][k]);
      chan6[k] = p6_fill ? fill_color[31-8*k -: 8] : acc[k][2*F+7:2*F];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= p6_valid;
    end
    red   <= chan6[0];
    green <= chan6[1];
    blue  <= chan6[2];
    alpha <= chan6[3];
  end

`ifndef SYNTHESIS
  a_result_follows_sample: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(start && !busy && mode == MODE_SAMPLE, 7))
    else $error("result without a matching sample");

  a_read_addr_in_range: assert property (@(posedge clk) disable iff (rst)
    p4_valid |-> (32'(rd_addr[0]) < 32'(TEXELS) && 32'(rd_addr[3]) < 32'(TEXELS)))
    else $error("texel address reduction out of range");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (p4_valid && p4_load) |=> !p5_valid)
    else $error("load produced a result");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;
  import tsb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEXELS = 4096;
  localparam int FRAC = 12;
  localparam int ONE = 1 << FRAC;
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic mode = MODE_LOAD;
  logic [11:0] texel_index = '0;
  logic [31:0] texel_rgba = '0;
  logic signed [15:0] u_coord = '0;
  logic signed [15:0] v_coord = '0;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = CFG_TEX_WIDTH;
  logic [31:0] cfg_data = '0;
  logic result_strobe;
  logic [7:0] red, green, blue, alpha;

  texture_sampler_bilinear dut (
    .clk, .rst, .start, .busy, .mode, .texel_index, .texel_rgba, .u_coord, .v_coord,
    .cfg_write, .cfg_index, .cfg_data, .result_strobe, .red, .green, .blue, .alpha
  );

  // shadow of the sampler state
  logic [31:0] tex_mem [TEXELS];
  bit written [TEXELS];
  logic [6:0] tex_w = 7'd1;
  logic [6:0] tex_h = 7'd1;
  logic wrap_sel = WRAP_FILL;
  logic filter_sel = FILTER_BILINEAR;
  logic [31:0] fill_rgba = '0;

  logic [31:0] expected_colors [$];
  int errors = 0;
  int idle_cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // works out which texels a sample reads and its blend weights
  function automatic void footprint(input logic signed [15:0] uc, input logic signed [15:0] vc,
                                    output int unsigned addr[4], output int cnt,
                                    output longint unsigned fu, output longint unsigned fv,
                                    output bit use_fill);
    int su, sv;
    int unsigned w, h, u, v, x, y, sx, sy, base;
    su = uc;
    sv = vc;
    w = (tex_w != 0) ? tex_w : 1;
    h = (tex_h != 0) ? tex_h : 1;
    use_fill = 1'b0;
    cnt = 0;
    fu = 0;
    fv = 0;
    addr = '{0, 0, 0, 0};
    if (su < 0 || su > ONE || sv < 0 || sv > ONE) begin
      if (wrap_sel == WRAP_FILL) begin
        use_fill = 1'b1;
        return;
      end
      u = su & (ONE - 1);
      v = sv & (ONE - 1);
    end else begin
      u = su;
      v = sv;
    end
    if (filter_sel == FILTER_NEAREST) begin
      x = (u * w) >> FRAC;
      y = (v * h) >> FRAC;
      if (x > w - 1) x = w - 1;
      if (y > h - 1) y = h - 1;
      addr[0] = (y * w + x) % TEXELS;
      cnt = 1;
    end else begin
      sx = u * (w - 1);
      sy = v * (h - 1);
      x = sx >> FRAC;
      y = sy >> FRAC;
      fu = sx & (ONE - 1);
      fv = sy & (ONE - 1);
      base = y * w + x;
      addr[0] = base % TEXELS;
      if (x == w - 1 || y == h - 1) begin
        cnt = 1;
      end else begin
        addr[1] = (base + 1) % TEXELS;
        addr[2] = (base + w) % TEXELS;
        addr[3] = (base + w + 1) % TEXELS;
        cnt = 4;
      end
    end
  endfunction

  function automatic logic [31:0] sampled_color(input logic signed [15:0] uc,
                                                input logic signed [15:0] vc);
    int unsigned addr[4];
    int cnt;
    longint unsigned fu, fv, gu, gv, acc;
    bit use_fill;
    logic [31:0] color;
    footprint(uc, vc, addr, cnt, fu, fv, use_fill);
    if (use_fill) return fill_rgba;
    if (cnt == 1) return tex_mem[addr[0]];
    gu = ONE - fu;
    gv = ONE - fv;
    for (int k = 0; k < 4; k++) begin
      acc = gu * gv * ((tex_mem[addr[0]] >> (24 - 8 * k)) & 8'hff)
          + fu * gv * ((tex_mem[addr[1]] >> (24 - 8 * k)) & 8'hff)
          + gu * fv * ((tex_mem[addr[2]] >> (24 - 8 * k)) & 8'hff)
          + fu * fv * ((tex_mem[addr[3]] >> (24 - 8 * k)) & 8'hff);
      color[31 - 8 * k -: 8] = 8'((acc >> (2 * FRAC)) & 8'hff);
    end
    return color;
  endfunction

  task automatic pause_random();
    int n;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: n = 0;
      19: n = $urandom_range(10, 40);
      default: n = $urandom_range(1, 3);
    endcase
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(input logic m, input logic [11:0] idx, input logic [31:0] rgba,
                           input logic signed [15:0] uc, input logic signed [15:0] vc);
    bit taken;
    start <= 1'b1;
    mode <= m;
    texel_index <= idx;
    texel_rgba <= rgba;
    u_coord <= uc;
    v_coord <= vc;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    if (m == MODE_LOAD) begin
      tex_mem[idx] = rgba;
      written[idx] = 1'b1;
    end else begin
      expected_colors.push_back(sampled_color(uc, vc));
    end
    pause_random();
  endtask

  task automatic load_texel(input int unsigned idx, input logic [31:0] rgba);
    send_item(MODE_LOAD, idx[11:0], rgba, 16'($urandom), 16'($urandom));
  endtask

  // loads any texel of the footprint that was never written, then samples
  task automatic sample_at(input logic signed [15:0] uc, input logic signed [15:0] vc);
    int unsigned addr[4];
    int cnt;
    longint unsigned fu, fv;
    bit use_fill;
    footprint(uc, vc, addr, cnt, fu, fv, use_fill);
    for (int i = 0; i < cnt; i++)
      if (!written[addr[i]]) load_texel(addr[i], $urandom);
    send_item(MODE_SAMPLE, 12'($urandom), $urandom, uc, vc);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_TEX_WIDTH: tex_w = data[6:0];
      CFG_TEX_HEIGHT: tex_h = data[6:0];
      CFG_WRAP_MODE: wrap_sel = data[0];
      CFG_FILTER_MODE: filter_sel = data[0];
      CFG_FILL_COLOR: fill_rgba = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input int w, input int h, input logic wrap, input logic filt,
                           input logic [31:0] fill);
    wait_idle();
    write_reg(CFG_TEX_WIDTH, 32'(w));
    write_reg(CFG_TEX_HEIGHT, 32'(h));
    write_reg(CFG_WRAP_MODE, 32'(wrap));
    write_reg(CFG_FILTER_MODE, 32'(filt));
    write_reg(CFG_FILL_COLOR, fill);
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 9))
      6: return $urandom_range(0, 1) ? 16'sd4096 : 16'sd0;
      7, 8, 9: return 16'($urandom);
      default: return 16'($urandom_range(0, ONE));
    endcase
  endfunction

  task automatic test_reset_defaults();
    sample_at(16'sd0, 16'sd0);
    sample_at(16'sd4096, 16'sd2048);
    sample_at(-16'sd1, 16'sd0);
  endtask

  task automatic test_directed();
    configure(4, 3, WRAP_FILL, FILTER_NEAREST, 32'hffffffff);
    load_texel(0, 32'h00000000);
    load_texel(11, 32'hffffffff);
    sample_at(16'sd0, 16'sd0);
    sample_at(16'sd4096, 16'sd4096);
    sample_at(16'sd4097, 16'sd0);
    sample_at(16'sd0, -16'sd32768);
    sample_at(16'sd32767, 16'sd32767);
    configure(4, 3, WRAP_REPEAT, FILTER_BILINEAR, 32'h12345678);
    sample_at(16'sd8192, 16'sd4096);
    sample_at(-16'sd2048, 16'sd1000);
    sample_at(16'sd2048, 16'sd2048);
    sample_at(16'sd4095, 16'sd100);
    sample_at(16'sd4096, 16'sd0);
    configure(0, 0, WRAP_FILL, FILTER_BILINEAR, 32'h0);
    sample_at(16'sd3000, 16'sd1000);
    configure(64, 64, WRAP_REPEAT, FILTER_NEAREST, 32'h0);
    sample_at(16'sd4096, 16'sd4096);
    sample_at(16'sd4095, 16'sd1);
    wait_idle();
    write_reg(CFG_FILTER_MODE, 32'(FILTER_BILINEAR));
    sample_at(16'sd4095, 16'sd4095);
    sample_at(16'sd1, 16'sd1);
  endtask

  task automatic test_random();
    int w, h;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin w = 1; h = 1; end
        1: begin w = 64; h = 64; end
        2: begin w = 64; h = 1; end
        3: begin w = 1; h = 64; end
        default: begin w = $urandom_range(1, 16); h = $urandom_range(1, 16); end
      endcase
      configure(w, h, 1'($urandom), 1'($urandom), $urandom);
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 3) == 0)
          load_texel($urandom_range(0, w * h - 1), $urandom);
        else
          sample_at(rand_coord(), rand_coord());
        if (i == 50) wait_idle();
      end
    end
  endtask

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && result_strobe) begin
      if (expected_colors.size() == 0) begin
        $error("result with no sample outstanding: %h%h%h%h", red, green, blue, alpha);
        errors++;
      end else begin
        want = expected_colors.pop_front();
        if (red !== want[31:24]) begin
          $error("red: expected %h, actual %h", want[31:24], red);
          errors++;
        end
        if (green !== want[23:16]) begin
          $error("green: expected %h, actual %h", want[23:16], green);
          errors++;
        end
        if (blue !== want[15:8]) begin
          $error("blue: expected %h, actual %h", want[15:8], blue);
          errors++;
        end
        if (alpha !== want[7:0]) begin
          $error("alpha: expected %h, actual %h", want[7:0], alpha);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < TEXELS; i++) written[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random();
    wait_idle();
    if (errors == 0 && expected_colors.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

FILE: texture_sampler_bilinear.f
rtl/tsb_pkg.sv
rtl/texture_sampler_bilinear.sv
tb/tb.sv
